// ===== hw/rtl/fmmri_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmmri_pkg - shared types and constants for the max-min inference block
// Field widths, index ranges, operation and status codes, address helpers.
// ----------------------------------------------------------------------------
package fmmri_pkg;

  localparam int unsigned OP_W         = 2;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned LIM_W        = IDX_W + 1;
  localparam int unsigned DEG_W        = 16;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned OVAR_W       = 2;
  localparam int unsigned OTERM_W      = 3;
  localparam int unsigned RULE_COUNT_W = 7;
  localparam int unsigned CFG_W        = 3;
  localparam int unsigned PAIR_W       = 2 * IDX_W;

  localparam int unsigned MAX_TERMS       = 8;
  localparam int unsigned MAX_INPUT_VARS  = 8;
  localparam int unsigned MAX_OUTPUT_VARS = 4;

  localparam int unsigned DEG_DEPTH = MAX_INPUT_VARS * MAX_TERMS;
  localparam int unsigned DEG_AW    = $clog2(DEG_DEPTH);
  localparam int unsigned AGG_DEPTH = MAX_OUTPUT_VARS * MAX_TERMS;
  localparam int unsigned AGG_AW    = $clog2(AGG_DEPTH);

  localparam logic [DEG_W-1:0] ONE_Q16 = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_ANTE   = 2'd0,
    OP_COMMIT     = 2'd1,
    OP_SET_DEGREE = 2'd2,
    OP_RUN        = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_ANTE_FULL  = 2'd1,
    STAT_TABLE_FULL = 2'd2,
    STAT_BAD_INDEX  = 2'd3
  } status_t;

  typedef enum logic {
    CMP_MIN = 1'b0,
    CMP_MAX = 1'b1
  } cmp_mode_t;

  // Non-negative and below the limit.
  function automatic logic idx_ok(input logic [IDX_W-1:0] v, input logic [LIM_W-1:0] lim);
    return !v[IDX_W-1] && ({1'b0, v} < lim);
  endfunction

  function automatic logic [DEG_AW-1:0] deg_addr(input logic [IDX_W-1:0] v,
                                                 input logic [IDX_W-1:0] t);
    return DEG_AW'(v) * DEG_AW'(MAX_TERMS) + DEG_AW'(t);
  endfunction

  function automatic logic [AGG_AW-1:0] agg_addr(input logic [IDX_W-1:0] v,
                                                 input logic [IDX_W-1:0] t);
    return AGG_AW'(v) * AGG_AW'(MAX_TERMS) + AGG_AW'(t);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fmmri_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmmri_ifs - request, result and configuration channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface fmmri_item_if;
  import fmmri_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [IDX_W-1:0]  var_index;
  logic signed [IDX_W-1:0]  term_index;
  logic [DEG_W-1:0]         degree_value;

  modport source (output valid, operation, var_index, term_index, degree_value,
                  input ready);
  modport sink   (input valid, operation, var_index, term_index, degree_value,
                  output ready);
endinterface

interface fmmri_result_if;
  import fmmri_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [OVAR_W-1:0]       out_var;
  logic [OTERM_W-1:0]      out_term;
  logic [DEG_W-1:0]        strength;
  logic [RULE_COUNT_W-1:0] rule_count;
  logic                    last;

  modport source (output valid, status, out_var, out_term, strength, rule_count, last,
                  input ready);
  modport sink   (input valid, status, out_var, out_term, strength, rule_count, last,
                  output ready);
endinterface

interface fmmri_cfg_if;
  import fmmri_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] num_output_vars;

  modport source (output valid, num_output_vars, input ready);
  modport sink   (input valid, num_output_vars, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fmmri_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmmri_ram - single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module fmmri_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fmmri_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmmri_cmp - shared compare-and-select unit
// One magnitude comparator serving the rule minimum and the term maximum.
// ----------------------------------------------------------------------------
module fmmri_cmp (
  input  wire fmmri_pkg::cmp_mode_t       mode,
  input  wire logic [fmmri_pkg::DEG_W-1:0] a,
  input  wire logic [fmmri_pkg::DEG_W-1:0] b,
  output      logic [fmmri_pkg::DEG_W-1:0] y
);
  import fmmri_pkg::*;

  logic b_lt_a;

  assign b_lt_a = (b < a);
  // min takes b when smaller, max takes b when not smaller
  assign y = (b_lt_a == (mode == CMP_MIN)) ? b : a;

endmodule
`default_nettype wire

// ===== hw/rtl/fuzzy_max_min_rule_inference.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_max_min_rule_inference - Mamdani max-min rule inference engine
// Builds a rule table and a degree table, then aggregates rule strengths.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  --------+-----------+----------------------------------------------------
//  item    | in        | operation, var_index, term_index, degree_value
//  result  | out       | status, out_var, out_term, strength, rule_count, last
//  cfg     | in        | num_output_vars (always ready)
//
//  Load requests (add antecedent, commit, set degree) each answer with a
//  single result; the next request is taken in the following cycle unless
//  that result is still held by the consumer.
//  A run walks every rule (an out-of-range antecedent ends its rule with
//  zero strength; a rule whose consequent is out of range adds nothing), then
//  emits one result for each term of each configured output variable,
//  stalling while the consumer holds one; the walk is bounded by the single
//  shared comparator and the one read port of each table. No request is
//  taken during a run.
//  Reset (synchronous, rst high) empties the rule table and pending rule by
//  count and the degree table by valid bits at once; there is no clearing pass.
//  A stalled result holds in the output register; the sequencer waits on it.
// ----------------------------------------------------------------------------
module fuzzy_max_min_rule_inference #(
  parameter int unsigned MAX_RULES       = 64,
  parameter int unsigned MAX_ANTECEDENTS = 4
) (
  input wire logic        clk,
  input wire logic        rst,
  fmmri_item_if.sink      item,
  fmmri_result_if.source  result,
  fmmri_cfg_if.sink       cfg
);
  import fmmri_pkg::*;

  localparam int unsigned RULE_CW    = $clog2(MAX_RULES + 1);
  localparam int unsigned RULE_AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned ANTE_CW    = $clog2(MAX_ANTECEDENTS + 1);
  localparam int unsigned ANTE_IW    = (MAX_ANTECEDENTS > 1) ? $clog2(MAX_ANTECEDENTS) : 1;
  localparam int unsigned ANTE_DEPTH = MAX_RULES * MAX_ANTECEDENTS;
  localparam int unsigned ANTE_AW    = (ANTE_DEPTH > 1) ? $clog2(ANTE_DEPTH) : 1;
  localparam int unsigned META_W     = ANTE_CW + PAIR_W;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_RULE    = 10'b00_0000_0010,
    S_META    = 10'b00_0000_0100,
    S_ANTE_RD = 10'b00_0000_1000,
    S_ANTE    = 10'b00_0001_0000,
    S_DEG     = 10'b00_0010_0000,
    S_AGG     = 10'b00_0100_0000,
    S_AGG_WR  = 10'b00_1000_0000,
    S_EMIT_RD = 10'b01_0000_0000,
    S_EMIT_LD = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // Architectural state.
  logic [RULE_CW-1:0] rule_total, rule_total_next;
  logic [ANTE_CW-1:0] pending_count, pending_next;
  logic [CFG_W-1:0]   nov_reg;

  // Run context.
  logic [CFG_W-1:0]   run_nov;
  logic [RULE_CW-1:0] r;
  logic [ANTE_IW-1:0] ai;
  logic [DEG_W-1:0]   acc;
  logic [OVAR_W-1:0]  emit_var;
  logic [OTERM_W-1:0] emit_term;

  // Output register.
  logic                    res_valid;
  status_t                 res_status;
  logic [OVAR_W-1:0]       res_var;
  logic [OTERM_W-1:0]      res_term;
  logic [DEG_W-1:0]        res_strength;
  logic [RULE_COUNT_W-1:0] res_rule_count;
  logic                    res_last;

  // Result load controls.
  logic               ld_res;
  status_t            ld_status;
  logic [OVAR_W-1:0]  ld_var;
  logic [OTERM_W-1:0] ld_term;
  logic [DEG_W-1:0]   ld_strength;
  logic               ld_last;

  // Request decode.
  logic             item_fire;
  logic             out_free;
  op_t              op;
  logic [IDX_W-1:0] vi;
  logic [IDX_W-1:0] ti;
  logic             pend_full;
  logic             rule_room;
  logic             deg_wr_ok;
  logic             run_start;
  logic [CFG_W-1:0] nov_clamped;

  // Degree table with reset valid bits.
  logic                 deg_we, deg_re;
  logic [DEG_AW-1:0]    deg_waddr, deg_raddr;
  logic [DEG_W-1:0]     deg_rdata, deg_data;
  logic [DEG_DEPTH-1:0] deg_valid;
  logic                 deg_valid_q;

  // Antecedent store.
  logic                ante_we, ante_re;
  logic [ANTE_AW-1:0]  ante_waddr, ante_raddr;
  logic [PAIR_W-1:0]   ante_rdata;
  logic [IDX_W-1:0]    avar, aterm;
  logic                ante_ok, ante_last;

  // Rule metadata: antecedent count and consequent.
  logic                meta_we, meta_re;
  logic [RULE_AW-1:0]  meta_waddr, meta_raddr;
  logic [META_W-1:0]   meta_wdata, meta_rdata;
  logic [ANTE_CW-1:0]  cnt;
  logic [IDX_W-1:0]    cvar, cterm;
  logic                cons_ok;
  logic                rules_done;

  // Aggregate store, valid bits cleared on each run.
  logic                 agg_we, agg_re;
  logic [AGG_AW-1:0]    cons_idx, emit_idx, agg_raddr;
  logic [DEG_W-1:0]     agg_rdata, agg_data;
  logic [AGG_DEPTH-1:0] agg_valid;
  logic                 agg_valid_q;
  logic                 emit_last;

  // Shared comparator.
  cmp_mode_t        cmp_mode;
  logic [DEG_W-1:0] cmp_a, cmp_b, cmp_y;

  // --------------------------------------------------------------------------
  // Handshake and request decode
  // --------------------------------------------------------------------------
  assign out_free   = !res_valid || result.ready;
  assign item.ready = (state == S_IDLE) && out_free;
  assign item_fire  = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign op        = op_t'(item.operation);
  assign vi        = item.var_index;
  assign ti        = item.term_index;
  assign pend_full = (pending_count >= ANTE_CW'(MAX_ANTECEDENTS));
  assign rule_room = (rule_total < RULE_CW'(MAX_RULES));
  assign deg_wr_ok = idx_ok(vi, LIM_W'(MAX_INPUT_VARS)) && idx_ok(ti, LIM_W'(MAX_TERMS));
  assign run_start = item_fire && (op == OP_RUN);

  // Saturate the output variable count into its legal range.
  always_comb begin
    if (nov_reg == '0) begin
      nov_clamped = CFG_W'(1);
    end else if (nov_reg > CFG_W'(MAX_OUTPUT_VARS)) begin
      nov_clamped = CFG_W'(MAX_OUTPUT_VARS);
    end else begin
      nov_clamped = nov_reg;
    end
  end

  // --------------------------------------------------------------------------
  // Table fields
  // --------------------------------------------------------------------------
  assign cnt   = meta_rdata[META_W-1 -: ANTE_CW];
  assign cvar  = meta_rdata[PAIR_W-1 -: IDX_W];
  assign cterm = meta_rdata[IDX_W-1:0];
  assign avar  = ante_rdata[PAIR_W-1 -: IDX_W];
  assign aterm = ante_rdata[IDX_W-1:0];

  assign rules_done = (r == rule_total);
  assign ante_ok    = idx_ok(avar, LIM_W'(MAX_INPUT_VARS)) && idx_ok(aterm, LIM_W'(MAX_TERMS));
  assign ante_last  = ((ANTE_CW'(ai) + ANTE_CW'(1)) == cnt);
  assign cons_ok    = idx_ok(cvar, LIM_W'(run_nov)) && idx_ok(cterm, LIM_W'(MAX_TERMS));
  assign cons_idx   = agg_addr(cvar, cterm);
  assign emit_idx   = agg_addr(IDX_W'(emit_var), IDX_W'(emit_term));
  assign emit_last  = (emit_var == OVAR_W'(run_nov - CFG_W'(1))) &&
                      (emit_term == OTERM_W'(MAX_TERMS - 1));

  // Entries never written since reset (or since the run began) read as zero.
  assign deg_data = deg_valid_q ? deg_rdata : '0;
  assign agg_data = agg_valid_q ? agg_rdata : '0;

  // --------------------------------------------------------------------------
  // Memory ports
  // --------------------------------------------------------------------------
  // Pending antecedents go straight into the slot of the rule being built;
  // a commit only has to record the count and the consequent.
  assign ante_we    = item_fire && (op == OP_ADD_ANTE) && !pend_full && rule_room;
  assign ante_waddr = ANTE_AW'(rule_total) * ANTE_AW'(MAX_ANTECEDENTS) +
                      ANTE_AW'(pending_count);
  assign ante_re    = (state == S_ANTE_RD);
  assign ante_raddr = ANTE_AW'(r) * ANTE_AW'(MAX_ANTECEDENTS) + ANTE_AW'(ai);

  assign meta_we    = item_fire && (op == OP_COMMIT) && rule_room;
  assign meta_waddr = RULE_AW'(rule_total);
  assign meta_wdata = {pending_count, vi, ti};
  assign meta_re    = (state == S_RULE) && !rules_done;
  assign meta_raddr = RULE_AW'(r);

  assign deg_we    = item_fire && (op == OP_SET_DEGREE) && deg_wr_ok;
  assign deg_waddr = deg_addr(vi, ti);
  assign deg_re    = (state == S_ANTE) && ante_ok;
  assign deg_raddr = deg_addr(avar, aterm);

  assign agg_we    = (state == S_AGG_WR);
  assign agg_re    = ((state == S_AGG) && cons_ok) || (state == S_EMIT_RD);
  assign agg_raddr = (state == S_EMIT_RD) ? emit_idx : cons_idx;

  fmmri_ram #(.WIDTH(PAIR_W), .DEPTH(ANTE_DEPTH), .AW(ANTE_AW)) u_ante_ram (
    .clk   (clk),
    .we    (ante_we),
    .waddr (ante_waddr),
    .wdata ({vi, ti}),
    .re    (ante_re),
    .raddr (ante_raddr),
    .rdata (ante_rdata)
  );

  fmmri_ram #(.WIDTH(META_W), .DEPTH(MAX_RULES), .AW(RULE_AW)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  fmmri_ram #(.WIDTH(DEG_W), .DEPTH(DEG_DEPTH), .AW(DEG_AW)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (item.degree_value),
    .re    (deg_re),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  fmmri_ram #(.WIDTH(DEG_W), .DEPTH(AGG_DEPTH), .AW(AGG_AW)) u_agg_ram (
    .clk   (clk),
    .we    (agg_we),
    .waddr (cons_idx),
    .wdata (cmp_y),
    .re    (agg_re),
    .raddr (agg_raddr),
    .rdata (agg_rdata)
  );

  // Valid bits travel with the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      deg_valid   <= '0;
      deg_valid_q <= 1'b0;
    end else begin
      if (deg_we) begin
        deg_valid[deg_waddr] <= 1'b1;
      end
      if (deg_re) begin
        deg_valid_q <= deg_valid[deg_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      agg_valid   <= '0;
      agg_valid_q <= 1'b0;
    end else begin
      if (run_start) begin
        agg_valid <= '0;
      end else if (agg_we) begin
        agg_valid[cons_idx] <= 1'b1;
      end
      if (agg_re) begin
        agg_valid_q <= agg_valid[agg_raddr];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared comparator: minimum over antecedents, maximum into the aggregate
  // --------------------------------------------------------------------------
  assign cmp_mode = (state == S_DEG) ? CMP_MIN : CMP_MAX;
  assign cmp_a    = (state == S_DEG) ? acc : agg_data;
  assign cmp_b    = (state == S_DEG) ? deg_data : acc;

  fmmri_cmp u_cmp (
    .mode (cmp_mode),
    .a    (cmp_a),
    .b    (cmp_b),
    .y    (cmp_y)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next      = state;
    rule_total_next = rule_total;
    pending_next    = pending_count;
    ld_res          = 1'b0;
    ld_status       = STAT_OK;
    ld_var          = '0;
    ld_term         = '0;
    ld_strength     = '0;
    ld_last         = 1'b1;
    case (state)
      S_IDLE: begin
        if (item_fire) begin
          ld_res = 1'b1;
          case (op)
            OP_ADD_ANTE: begin
              if (pend_full) begin
                ld_status = STAT_ANTE_FULL;
              end else begin
                pending_next = pending_count + ANTE_CW'(1);
              end
            end
            OP_COMMIT: begin
              if (!rule_room) begin
                ld_status = STAT_TABLE_FULL;
              end else begin
                rule_total_next = rule_total + RULE_CW'(1);
              end
              // drop the pending rule either way
              pending_next = '0;
            end
            OP_SET_DEGREE: begin
              if (!deg_wr_ok) begin
                ld_status = STAT_BAD_INDEX;
              end
            end
            OP_RUN: begin
              ld_res     = 1'b0;
              state_next = S_RULE;
            end
            default: begin
              ld_res = 1'b0;
            end
          endcase
        end
      end
      S_RULE:    state_next = rules_done ? S_EMIT_RD : S_META;
      S_META:    state_next = (cnt == '0) ? S_AGG : S_ANTE_RD;
      S_ANTE_RD: state_next = S_ANTE;
      S_ANTE:    state_next = ante_ok ? S_DEG : S_AGG;
      S_DEG:     state_next = ante_last ? S_AGG : S_ANTE_RD;
      S_AGG:     state_next = cons_ok ? S_AGG_WR : S_RULE;
      S_AGG_WR:  state_next = S_RULE;
      S_EMIT_RD: state_next = S_EMIT_LD;
      S_EMIT_LD: begin
        // hold the read data until the output register is free
        if (out_free) begin
          ld_res      = 1'b1;
          ld_var      = emit_var;
          ld_term     = emit_term;
          ld_strength = agg_data;
          ld_last     = emit_last;
          state_next  = emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rule_total    <= '0;
      pending_count <= '0;
      nov_reg       <= CFG_W'(1);
      run_nov       <= CFG_W'(1);
      r             <= '0;
      ai            <= '0;
      acc           <= '0;
      emit_var      <= '0;
      emit_term     <= '0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      rule_total    <= rule_total_next;
      pending_count <= pending_next;
      if (cfg.valid) begin
        nov_reg <= cfg.num_output_vars;
      end
      if (ld_res) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (run_start) begin
            r         <= '0;
            emit_var  <= '0;
            emit_term <= '0;
            run_nov   <= nov_clamped;
          end
        end
        S_META: begin
          ai  <= '0;
          // a rule with no antecedents has zero strength
          acc <= (cnt == '0) ? '0 : ONE_Q16;
        end
        S_ANTE: begin
          if (!ante_ok) begin
            acc <= '0;
          end
        end
        S_DEG: begin
          acc <= cmp_y;
          ai  <= ai + ANTE_IW'(1);
        end
        S_AGG: begin
          if (!cons_ok) begin
            r <= r + RULE_CW'(1);
          end
        end
        S_AGG_WR: begin
          r <= r + RULE_CW'(1);
        end
        S_EMIT_LD: begin
          if (out_free && !emit_last) begin
            if (emit_term == OTERM_W'(MAX_TERMS - 1)) begin
              emit_term <= '0;
              emit_var  <= emit_var + OVAR_W'(1);
            end else begin
              emit_term <= emit_term + OTERM_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result payload; rule_count reflects the table after this request.
  always_ff @(posedge clk) begin
    if (ld_res) begin
      res_status     <= ld_status;
      res_var        <= ld_var;
      res_term       <= ld_term;
      res_strength   <= ld_strength;
      res_rule_count <= RULE_COUNT_W'(rule_total_next);
      res_last       <= ld_last;
    end
  end

  assign result.valid      = res_valid;
  assign result.status     = res_status;
  assign result.out_var    = res_var;
  assign result.out_term   = res_term;
  assign result.strength   = res_strength;
  assign result.rule_count = res_rule_count;
  assign result.last       = res_last;

endmodule
`default_nettype wire

// ===== hw/rtl/fmmri_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmmri_assertions - port-level assertions for the inference block
// Watches the request and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module fmmri_assertions (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_valid,
  input wire logic                          item_ready,
  input wire logic                          res_valid,
  input wire logic                          res_ready,
  input wire logic [fmmri_pkg::STAT_W-1:0]  res_status,
  input wire logic [fmmri_pkg::DEG_W-1:0]   res_strength,
  input wire logic                          res_last
);
  import fmmri_pkg::*;

  // A held result stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before it was taken");

  // A held result keeps its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_strength) && $stable(res_last))
    else $error("result payload changed while stalled");

  // Error answers are single, final results with no strength.
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != STAT_OK) |-> res_last && (res_strength == '0))
    else $error("error result not final or carries strength");

  // Only run output carries more than one result, and it is always ok.
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> res_status == STAT_OK)
    else $error("non-final result with error status");

  // No new request is taken while a run is still emitting.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |-> !(res_valid && !res_last))
    else $error("request accepted in the middle of a run");

endmodule

bind fuzzy_max_min_rule_inference fmmri_assertions u_fmmri_assertions (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_status   (result.status),
  .res_strength (result.strength),
  .res_last     (result.last)
);
`default_nettype wire

// ===== dv/fmmri_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmmri_checker - result predictor and comparator for the max-min engine
// Watches the request, result and configuration channels, keeps its own copy
// of the degree and rule tables, and checks every result in arrival order.
// ----------------------------------------------------------------------------
module fmmri_checker
  import fmmri_pkg::*;
#(
  parameter int unsigned RULE_CAP = 64,
  parameter int unsigned ANTE_CAP = 4
) (
  input  logic           clk,
  input  logic           rst,
  fmmri_item_if          item,
  fmmri_result_if        result,
  fmmri_cfg_if           cfg,
  output int unsigned    answers_outstanding,
  output int unsigned    failures
);

  typedef logic signed [IDX_W-1:0] idx_t;

  typedef struct packed {
    status_t                 status;
    logic [OVAR_W-1:0]       out_var;
    logic [OTERM_W-1:0]      out_term;
    logic [DEG_W-1:0]        strength;
    logic [RULE_COUNT_W-1:0] rule_count;
    logic                    last;
  } answer_t;

  logic [DEG_W-1:0] degrees [DEG_DEPTH];
  idx_t             ante_var  [RULE_CAP*ANTE_CAP];
  idx_t             ante_term [RULE_CAP*ANTE_CAP];
  int unsigned      ante_len  [RULE_CAP];
  idx_t             cons_var  [RULE_CAP];
  idx_t             cons_term [RULE_CAP];
  int unsigned      rules_held;
  idx_t             draft_var  [ANTE_CAP];
  idx_t             draft_term [ANTE_CAP];
  int unsigned      draft_len;
  logic [CFG_W-1:0] out_vars_reg;

  answer_t     due_answers [$];
  int unsigned err_total   = 0;

  assign failures = err_total;

  function automatic bit in_range(input idx_t x, input int lim);
    return int'(x) >= 0 && int'(x) < lim;
  endfunction

  // Minimum over the rule's antecedent degrees; any bad index kills the rule.
  function automatic logic [DEG_W-1:0] firing_strength(input int unsigned r);
    logic [DEG_W-1:0] s;
    idx_t             v;
    idx_t             t;
    if (ante_len[r] == 0) return '0;
    s = ONE_Q16;
    for (int unsigned i = 0; i < ante_len[r]; i++) begin
      v = ante_var[r*ANTE_CAP+i];
      t = ante_term[r*ANTE_CAP+i];
      if (!in_range(v, MAX_INPUT_VARS) || !in_range(t, MAX_TERMS)) return '0;
      if (degrees[int'(v)*MAX_TERMS+int'(t)] < s) s = degrees[int'(v)*MAX_TERMS+int'(t)];
    end
    return s;
  endfunction

  task automatic queue_answer(input status_t st, input int v, input int t,
                              input logic [DEG_W-1:0] s, input bit fin);
    answer_t a;
    a.status     = st;
    a.out_var    = OVAR_W'(v);
    a.out_term   = OTERM_W'(t);
    a.strength   = s;
    a.rule_count = RULE_COUNT_W'(rules_held);
    a.last       = fin;
    due_answers.push_back(a);
  endtask

  task automatic evaluate_request(input logic [OP_W-1:0] op, input idx_t v, input idx_t t,
                                  input logic [DEG_W-1:0] d);
    status_t          st;
    logic [DEG_W-1:0] agg [AGG_DEPTH];
    logic [DEG_W-1:0] s;
    int               nov;
    int               idx;
    st = STAT_OK;
    case (op)
      OP_ADD_ANTE: begin
        if (draft_len >= ANTE_CAP) begin
          st = STAT_ANTE_FULL;
        end else begin
          draft_var[draft_len]  = v;
          draft_term[draft_len] = t;
          draft_len++;
        end
      end
      OP_COMMIT: begin
        if (rules_held >= RULE_CAP) begin
          st = STAT_TABLE_FULL;
        end else begin
          for (int unsigned i = 0; i < draft_len; i++) begin
            ante_var[rules_held*ANTE_CAP+i]  = draft_var[i];
            ante_term[rules_held*ANTE_CAP+i] = draft_term[i];
          end
          ante_len[rules_held]  = draft_len;
          cons_var[rules_held]  = v;
          cons_term[rules_held] = t;
          rules_held++;
        end
        draft_len = 0;
      end
      OP_SET_DEGREE: begin
        if (!in_range(v, MAX_INPUT_VARS) || !in_range(t, MAX_TERMS))
          st = STAT_BAD_INDEX;
        else
          degrees[int'(v)*MAX_TERMS+int'(t)] = d;
      end
      default: begin
        nov = out_vars_reg;
        if (nov < 1) nov = 1;
        if (nov > MAX_OUTPUT_VARS) nov = MAX_OUTPUT_VARS;
        foreach (agg[i]) agg[i] = '0;
        for (int unsigned r = 0; r < rules_held; r++) begin
          if (!in_range(cons_var[r], nov) || !in_range(cons_term[r], MAX_TERMS)) continue;
          s   = firing_strength(r);
          idx = int'(cons_var[r]) * MAX_TERMS + int'(cons_term[r]);
          if (s > agg[idx]) agg[idx] = s;
        end
        for (int ov = 0; ov < nov; ov++) begin
          for (int ot = 0; ot < MAX_TERMS; ot++) begin
            queue_answer(STAT_OK, ov, ot, agg[ov*MAX_TERMS+ot],
                         ov == nov - 1 && ot == MAX_TERMS - 1);
          end
        end
        return;
      end
    endcase
    queue_answer(st, 0, 0, '0, 1'b1);
  endtask

  function automatic bit field_differs(input string name, input int unsigned want,
                                       input int unsigned got);
    if (want == got) return 1'b0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    bit      bad;
    if (rst) begin
      foreach (degrees[i]) degrees[i] = '0;
      rules_held   = 0;
      draft_len    = 0;
      out_vars_reg = 3'd1;
      due_answers.delete();
    end else begin
      if (cfg.valid && cfg.ready) out_vars_reg = cfg.num_output_vars;
      if (result.valid && result.ready) begin
        if (due_answers.size() == 0) begin
          err_total++;
          $display({"%0t: result mismatch, expected none, actual status %0d var %0d",
                    " term %0d strength %0d count %0d last %0d"},
                   $time, result.status, result.out_var, result.out_term,
                   result.strength, result.rule_count, result.last);
        end else begin
          want = due_answers.pop_front();
          bad  = 1'b0;
          bad |= field_differs("status", want.status, result.status);
          bad |= field_differs("out_var", want.out_var, result.out_var);
          bad |= field_differs("out_term", want.out_term, result.out_term);
          bad |= field_differs("strength", want.strength, result.strength);
          bad |= field_differs("rule_count", want.rule_count, result.rule_count);
          bad |= field_differs("last", want.last, result.last);
          if (bad) err_total++;
        end
      end
      if (item.valid && item.ready)
        evaluate_request(item.operation, item.var_index, item.term_index, item.degree_value);
    end
    answers_outstanding <= due_answers.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - regression bench for the max-min fuzzy rule inference engine
// Drives directed and random request streams through several idling phases
// and configuration settings; the checker beside the block predicts results.
// ----------------------------------------------------------------------------
module tb_top;
  import fmmri_pkg::*;

  localparam int unsigned RULE_CAP        = 64;
  localparam int unsigned ANTE_CAP        = 4;
  localparam int          CLK_PERIOD      = 8;
  localparam int unsigned RESET_CYCLES    = 9;
  // Quiet limit, well above the length of a full table walk.
  localparam int unsigned QUIET_LIMIT     = 8000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned PHASE_ITEMS     = 88;
  localparam int unsigned PRESSURE_ITEMS  = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Percentages steering the two sides, changed between phases.
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  // Bump to ask the receiver for one long hold-off.
  int unsigned hold_seq   = 0;
  int unsigned items_sent = 0;

  int unsigned answers_outstanding;
  int unsigned failures;

  fmmri_item_if   item_ch ();
  fmmri_result_if result_ch ();
  fmmri_cfg_if    cfg_ch ();

  fuzzy_max_min_rule_inference #(
    .MAX_RULES       (RULE_CAP),
    .MAX_ANTECEDENTS (ANTE_CAP)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  fmmri_checker #(
    .RULE_CAP (RULE_CAP),
    .ANTE_CAP (ANTE_CAP)
  ) u_check (
    .clk                 (clk),
    .rst                 (rst),
    .item                (item_ch),
    .result              (result_ch),
    .cfg                 (cfg_ch),
    .answers_outstanding (answers_outstanding),
    .failures            (failures)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up when no channel has moved anything for too long.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Idle cycles
  // before it drop valid; an accepted request leaves valid up for the next.
  task automatic offer(input op_t op, input logic signed [IDX_W-1:0] v,
                       input logic signed [IDX_W-1:0] t, input logic [DEG_W-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.operation    <= op;
    item_ch.var_index    <= v;
    item_ch.term_index   <= t;
    item_ch.degree_value <= d;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Mostly an in-range index; now and then any 4-bit pattern, negatives too.
  function automatic logic signed [IDX_W-1:0] pick_index(input int unsigned lim,
                                                         input int unsigned wild_pct);
    if ($urandom_range(99) < wild_pct) return IDX_W'($urandom);
    return IDX_W'($urandom_range(lim - 1));
  endfunction

  function automatic logic [DEG_W-1:0] pick_degree();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ONE_Q16;
      2:       return 16'h0001;
      3:       return 16'hFFFE;
      default: return DEG_W'($urandom);
    endcase
  endfunction

  // Stop sending, then wait for every expected result to come back. The
  // outstanding count is registered, so let it catch up first.
  task automatic wait_quiet();
    item_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (answers_outstanding != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] nov);
    wait_quiet();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.num_output_vars <= nov;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One rule: up to four antecedents (sometimes five or six) and a commit, indices now and then out of range.
  task automatic build_rule();
    int unsigned n;
    n = ($urandom_range(99) < 12) ? $urandom_range(6, 5) : $urandom_range(4, 0);
    repeat (n)
      offer(OP_ADD_ANTE, pick_index(MAX_INPUT_VARS, 8), pick_index(MAX_TERMS, 8),
            DEG_W'($urandom));
    offer(OP_COMMIT, pick_index(MAX_OUTPUT_VARS, 15), pick_index(MAX_TERMS, 10),
          DEG_W'($urandom));
  endtask

  task automatic random_group();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      build_rule();
    end else if (pick < 75) begin
      repeat ($urandom_range(4, 1))
        offer(OP_SET_DEGREE, pick_index(MAX_INPUT_VARS, 6), pick_index(MAX_TERMS, 6),
              pick_degree());
    end else if (pick < 88) begin
      offer(OP_RUN, IDX_W'($urandom), IDX_W'($urandom), DEG_W'($urandom));
    end else begin
      // Noise: any operation with raw field patterns.
      offer(op_t'($urandom_range(3)), IDX_W'($urandom), IDX_W'($urandom), DEG_W'($urandom));
    end
  endtask

  task automatic random_phase(input int unsigned idle, input int unsigned stall);
    int unsigned start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = items_sent;
    while (items_sent - start < PHASE_ITEMS) random_group();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    item_ch.valid          = 1'b0;
    item_ch.operation      = '0;
    item_ch.var_index      = '0;
    item_ch.term_index     = '0;
    item_ch.degree_value   = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.num_output_vars = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling on either side.
    // Run on an empty table with the reset setting: all strengths zero.
    offer(OP_RUN, 4'sd0, 4'sd0, 16'h0000);
    // Degree extremes, then two requests with a negative index.
    offer(OP_SET_DEGREE, 4'sd0, 4'sd0, ONE_Q16);
    offer(OP_SET_DEGREE, 4'sd7, 4'sd7, 16'h0000);
    offer(OP_SET_DEGREE, 4'sd3, 4'sd5, 16'h8000);
    offer(OP_SET_DEGREE, 4'sd7, 4'sd0, 16'h0001);
    offer(OP_SET_DEGREE, -4'sd1, 4'sd2, 16'h1234);
    offer(OP_SET_DEGREE, 4'sd4, -4'sd8, 16'hABCD);
    // Fill the pending list, then overflow it once.
    offer(OP_ADD_ANTE, 4'sd0, 4'sd0, 16'h0000);
    offer(OP_ADD_ANTE, 4'sd3, 4'sd5, 16'hFFFF);
    offer(OP_ADD_ANTE, 4'sd7, 4'sd0, 16'h0000);
    offer(OP_ADD_ANTE, 4'sd0, 4'sd0, 16'hFFFF);
    offer(OP_ADD_ANTE, 4'sd5, 4'sd5, 16'h0000);
    offer(OP_COMMIT, 4'sd0, 4'sd0, 16'h0000);
    // Rule with no antecedents, on a variable seen only with wider settings.
    offer(OP_COMMIT, 4'sd1, 4'sd7, 16'h0000);
    // Rule with a negative antecedent index.
    offer(OP_ADD_ANTE, -4'sd1, 4'sd3, 16'h0000);
    offer(OP_COMMIT, 4'sd0, 4'sd1, 16'h0000);
    // Consequents out of range: negative variable, variable beyond the
    // current setting, negative term.
    offer(OP_ADD_ANTE, 4'sd3, 4'sd5, 16'h0000);
    offer(OP_COMMIT, -4'sd1, 4'sd0, 16'h0000);
    offer(OP_ADD_ANTE, 4'sd0, 4'sd0, 16'h0000);
    offer(OP_COMMIT, 4'sd3, 4'sd7, 16'h0000);
    offer(OP_ADD_ANTE, 4'sd3, 4'sd5, 16'h0000);
    offer(OP_COMMIT, 4'sd0, -4'sd1, 16'h0000);
    offer(OP_RUN, 4'sd0, 4'sd0, 16'h0000);
    // Widest setting brings in variables 1 and 3.
    write_config(3'd4);
    offer(OP_RUN, 4'sd0, 4'sd0, 16'h0000);
    write_config(3'd1);
    offer(OP_RUN, -4'sd8, -4'sd8, 16'hFFFF);

    // Random phases, each under a fresh setting, the block idle in between.
    write_config(3'd4);
    random_phase(0, 0);
    write_config(3'd0);
    random_phase(65, 0);
    write_config(3'd7);
    random_phase(0, 65);

    // Pressure: hold the result side off while the sender keeps offering,
    // so the output register fills and the block stalls its input.
    write_config(3'd2);
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq++;
    repeat (PRESSURE_ITEMS)
      offer(op_t'($urandom_range(2)), pick_index(MAX_INPUT_VARS, 10),
            pick_index(MAX_TERMS, 10), pick_degree());

    write_config(CFG_W'($urandom));
    random_phase(27, 27);

    // Drain, then give the block time to show any stray result.
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && answers_outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fmmri_pkg.sv
hw/rtl/fmmri_ifs.sv
hw/rtl/fmmri_ram.sv
hw/rtl/fmmri_cmp.sv
hw/rtl/fuzzy_max_min_rule_inference.sv
hw/rtl/fmmri_checker.sv
dv/fmmri_checker.sv
dv/tb_top.sv
